### rtl/acd_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the axisymmetric current direction unit
// depends on nothing; used by the top level and the testbench

package acd_pkg;

   // node and origin coordinate width, Q15.16 style signed
   localparam int COORD_WIDTH = 32;
   // configuration write data is as wide as the widest register
   localparam int CSR_WIDTH   = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
   // right shift that brings an offset back into 32 bits
   localparam int PSHIFT      = (COORD_WIDTH > 31) ? COORD_WIDTH - 31 : 0;
   // digit steps of the square root and of the divide
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 31;
   // request to result pipeline depth in registers
   localparam int LATENCY     = 9 + SQRT_STEPS + 1 + DIV_STEPS + 3;

   typedef logic signed [31:0] fix_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_CURRENT_REAL = 3'd0,
      CSR_CURRENT_IMAG = 3'd1,
      CSR_ORIGIN_X     = 3'd2,
      CSR_ORIGIN_Y     = 3'd3,
      CSR_ORIGIN_Z     = 3'd4,
      CSR_AXIS_X       = 3'd5,
      CSR_AXIS_Y       = 3'd6,
      CSR_AXIS_Z       = 3'd7
   } csr_index_type;

endpackage

### rtl/axisymmetric_current_direction_unit.sv
`timescale 1ns / 1ps
// requests pass stages a to m, the root steps after i and divide steps after j
// throughput: one request per cycle; the whole pipeline holds while a result
// waits under rsp_stall, the 32 root steps and 31 divide steps set the depth
// reset (synchronous, active high): pipeline valid bits and all configuration
// registers clear to zero; no clearing pass, the unit accepts at once
// depends on acd_pkg

module axisymmetric_current_direction_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [acd_pkg::COORD_WIDTH-1:0] req_node_x,
   input  logic signed [acd_pkg::COORD_WIDTH-1:0] req_node_y,
   input  logic signed [acd_pkg::COORD_WIDTH-1:0] req_node_z,
   input  logic                                req_vertex_last,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_j_x_real,
   output logic signed [31:0]                  rsp_j_x_imag,
   output logic signed [31:0]                  rsp_j_y_real,
   output logic signed [31:0]                  rsp_j_y_imag,
   output logic signed [31:0]                  rsp_j_z_real,
   output logic signed [31:0]                  rsp_j_z_imag,
   output logic                                rsp_last_out,
   // configuration write port
   input  logic                                csr_wen,
   input  logic [2:0]                          csr_index,
   input  logic [acd_pkg::CSR_WIDTH-1:0]       csr_wdata
);

   localparam int CW = acd_pkg::COORD_WIDTH;
   localparam int SN = acd_pkg::SQRT_STEPS;
   localparam int DN = acd_pkg::DIV_STEPS;

   // configuration registers
   acd_pkg::fix_type       current_real_ff, current_imag_ff;
   logic signed [CW-1:0]   origin_ff [3];
   acd_pkg::fix_type       axis_ff   [3];

   // global advance: the pipeline moves unless a result is held
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         current_real_ff <= '0;
         current_imag_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            origin_ff[i] <= '0;
            axis_ff[i]   <= '0;
         end
      end else if (csr_wen) begin
         unique case (acd_pkg::csr_index_type'(csr_index))
            acd_pkg::CSR_CURRENT_REAL: current_real_ff <= csr_wdata[31:0];
            acd_pkg::CSR_CURRENT_IMAG: current_imag_ff <= csr_wdata[31:0];
            acd_pkg::CSR_ORIGIN_X:     origin_ff[0]    <= csr_wdata[CW-1:0];
            acd_pkg::CSR_ORIGIN_Y:     origin_ff[1]    <= csr_wdata[CW-1:0];
            acd_pkg::CSR_ORIGIN_Z:     origin_ff[2]    <= csr_wdata[CW-1:0];
            acd_pkg::CSR_AXIS_X:       axis_ff[0]      <= csr_wdata[31:0];
            acd_pkg::CSR_AXIS_Y:       axis_ff[1]      <= csr_wdata[31:0];
            acd_pkg::CSR_AXIS_Z:       axis_ff[2]      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage a: offset from the origin, scaled back into 32 bits
   logic signed [CW-1:0] node_w [3];
   logic signed [63:0]   diff_in [3];
   acd_pkg::fix_type     a_p_in [3];
   acd_pkg::fix_type     a_p_ff [3];
   logic                 a_valid_ff, a_last_ff;

   assign node_w[0] = req_node_x;
   assign node_w[1] = req_node_y;
   assign node_w[2] = req_node_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = 64'(node_w[i]) - 64'(origin_ff[i]);
         a_p_in[i]  = 32'(diff_in[i] >>> acd_pkg::PSHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (advance) a_valid_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         a_last_ff <= req_vertex_last;
         a_p_ff    <= a_p_in;
      end
   end

   // ---------------------------------------------------------------
   // stage b: the six partial products of the cross product
   logic signed [63:0] b_prod_in [6];
   logic signed [63:0] b_prod_ff [6];
   logic               b_valid_ff, b_last_ff;

   always_comb begin
      b_prod_in[0] = 64'(axis_ff[1]) * 64'(a_p_ff[2]);
      b_prod_in[1] = 64'(axis_ff[2]) * 64'(a_p_ff[1]);
      b_prod_in[2] = 64'(axis_ff[2]) * 64'(a_p_ff[0]);
      b_prod_in[3] = 64'(axis_ff[0]) * 64'(a_p_ff[2]);
      b_prod_in[4] = 64'(axis_ff[0]) * 64'(a_p_ff[1]);
      b_prod_in[5] = 64'(axis_ff[1]) * 64'(a_p_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (advance) b_valid_ff <= a_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b_last_ff <= a_last_ff;
         b_prod_ff <= b_prod_in;
      end
   end

   // ---------------------------------------------------------------
   // stage c: cross product components
   logic signed [63:0] c_r_ff [3];
   logic               c_valid_ff, c_last_ff;

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (advance) c_valid_ff <= b_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         c_last_ff <= b_last_ff;
         for (int i = 0; i < 3; i++) c_r_ff[i] <= b_prod_ff[2*i] - b_prod_ff[2*i+1];
      end
   end

   // ---------------------------------------------------------------
   // stage d: or of the magnitudes has the bit length of the largest one
   logic [63:0]        d_mag_in [3];
   logic [63:0]        d_or_in;
   logic [63:0]        d_or_ff;
   logic signed [63:0] d_r_ff [3];
   logic               d_valid_ff, d_last_ff;

   always_comb begin
      d_or_in = '0;
      for (int i = 0; i < 3; i++) begin
         d_mag_in[i] = c_r_ff[i][63] ? 64'(-c_r_ff[i]) : 64'(c_r_ff[i]);
         d_or_in     = d_or_in | d_mag_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else if (advance) d_valid_ff <= c_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         d_last_ff <= c_last_ff;
         d_r_ff    <= c_r_ff;
         d_or_ff   <= d_or_in;
      end
   end

   // ---------------------------------------------------------------
   // stage e: leading one search inside each byte
   logic [7:0]         e_nz_in;
   logic [2:0]         e_pos_in [8];
   logic [7:0]         e_nz_ff;
   logic [2:0]         e_pos_ff [8];
   logic signed [63:0] e_r_ff [3];
   logic               e_valid_ff, e_last_ff;

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         e_nz_in[g]  = |d_or_ff[8*g +: 8];
         e_pos_in[g] = '0;
         for (int j = 0; j < 8; j++) begin
            if (d_or_ff[8*g + j]) e_pos_in[g] = 3'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else if (advance) e_valid_ff <= d_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         e_last_ff <= d_last_ff;
         e_r_ff    <= d_r_ff;
         e_nz_ff   <= e_nz_in;
         e_pos_ff  <= e_pos_in;
      end
   end

   // ---------------------------------------------------------------
   // stage f: bit length of the largest component, zero for a null vector
   logic [6:0]         f_len_in;
   logic [6:0]         f_len_ff;
   logic signed [63:0] f_r_ff [3];
   logic               f_valid_ff, f_last_ff;

   always_comb begin
      f_len_in = '0;
      for (int g = 0; g < 8; g++) begin
         if (e_nz_ff[g]) f_len_in = 7'(g * 8) + 7'(e_pos_ff[g]) + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f_valid_ff <= 1'b0;
      else if (advance) f_valid_ff <= e_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         f_last_ff <= e_last_ff;
         f_r_ff    <= e_r_ff;
         f_len_ff  <= f_len_in;
      end
   end

   // ---------------------------------------------------------------
   // stage g: block scaling so that the largest magnitude is 31 bits long
   acd_pkg::fix_type g_rs_in [3];
   logic [31:0]      g_mag_in [3];
   logic [31:0]      g_mag_ff [3];
   logic             g_neg_ff [3];
   logic             g_valid_ff, g_last_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (f_len_ff > 7'd31) g_rs_in[i] = 32'(f_r_ff[i] >>> 7'(f_len_ff - 7'd31));
         else                  g_rs_in[i] = 32'(f_r_ff[i] <<< 7'(7'd31 - f_len_ff));
         g_mag_in[i] = g_rs_in[i][31] ? 32'(-g_rs_in[i]) : 32'(g_rs_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) g_valid_ff <= 1'b0;
      else if (advance) g_valid_ff <= f_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         g_last_ff <= f_last_ff;
         g_mag_ff  <= g_mag_in;
         for (int i = 0; i < 3; i++) g_neg_ff[i] <= g_rs_in[i][31];
      end
   end

   // ---------------------------------------------------------------
   // stage h: squares of the scaled magnitudes
   logic [63:0] h_sq_ff [3];
   logic [31:0] h_mag_ff [3];
   logic        h_neg_ff [3];
   logic        h_valid_ff, h_last_ff;

   always_ff @(posedge clock) begin
      if (reset) h_valid_ff <= 1'b0;
      else if (advance) h_valid_ff <= g_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         h_last_ff <= g_last_ff;
         h_mag_ff  <= g_mag_ff;
         h_neg_ff  <= g_neg_ff;
         for (int i = 0; i < 3; i++) h_sq_ff[i] <= 64'(g_mag_ff[i]) * 64'(g_mag_ff[i]);
      end
   end

   // ---------------------------------------------------------------
   // stage i and root steps: sum of squares, then one root bit per stage
   logic        s_valid_ff [SN+1];
   logic        s_last_ff  [SN+1];
   logic [63:0] s_v_ff     [SN+1];
   logic [32:0] s_rem_ff   [SN+1];
   logic [31:0] s_root_ff  [SN+1];
   logic [31:0] s_mag_ff   [SN+1][3];
   logic        s_neg_ff   [SN+1][3];

   always_ff @(posedge clock) begin
      if (reset) s_valid_ff[0] <= 1'b0;
      else if (advance) s_valid_ff[0] <= h_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s_last_ff[0] <= h_last_ff;
         s_v_ff[0]    <= h_sq_ff[0] + h_sq_ff[1] + h_sq_ff[2];
         s_rem_ff[0]  <= '0;
         s_root_ff[0] <= '0;
         s_mag_ff[0]  <= h_mag_ff;
         s_neg_ff[0]  <= h_neg_ff;
      end
   end

   for (genvar k = 0; k < SN; k++) begin : g_sqrt
      logic [34:0] t_in;
      logic [33:0] trial_in;
      logic        ge_in;

      // restoring square root digit
      always_comb begin
         t_in     = {s_rem_ff[k], s_v_ff[k][2*(SN-1-k) +: 2]};
         trial_in = {s_root_ff[k], 2'b01};
         ge_in    = t_in >= 35'(trial_in);
      end

      always_ff @(posedge clock) begin
         if (reset) s_valid_ff[k+1] <= 1'b0;
         else if (advance) s_valid_ff[k+1] <= s_valid_ff[k];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            s_last_ff[k+1] <= s_last_ff[k];
            s_v_ff[k+1]    <= s_v_ff[k];
            s_mag_ff[k+1]  <= s_mag_ff[k];
            s_neg_ff[k+1]  <= s_neg_ff[k];
            s_rem_ff[k+1]  <= ge_in ? 33'(t_in - 35'(trial_in)) : 33'(t_in);
            s_root_ff[k+1] <= {s_root_ff[k][30:0], ge_in};
         end
      end
   end

   // ---------------------------------------------------------------
   // stage j and divide steps: rounded |r| * 2^30 / n, one quotient bit per stage
   logic        q_valid_ff [DN+1];
   logic        q_last_ff  [DN+1];
   logic [31:0] q_den_ff   [DN+1];
   logic [61:0] q_num_ff   [DN+1][3];
   logic [31:0] q_rem_ff   [DN+1][3];
   logic [30:0] q_quo_ff   [DN+1][3];
   logic        q_neg_ff   [DN+1][3];
   logic [31:0] j_den_in;
   logic [61:0] j_num_in [3];

   always_comb begin
      j_den_in = (s_root_ff[SN] == '0) ? 32'd1 : s_root_ff[SN];
      for (int i = 0; i < 3; i++) begin
         j_num_in[i] = {s_mag_ff[SN][i], 30'b0} + 62'(j_den_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_valid_ff[0] <= 1'b0;
      else if (advance) q_valid_ff[0] <= s_valid_ff[SN];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         q_last_ff[0] <= s_last_ff[SN];
         q_den_ff[0]  <= j_den_in;
         q_neg_ff[0]  <= s_neg_ff[SN];
         q_num_ff[0]  <= j_num_in;
         for (int i = 0; i < 3; i++) begin
            q_rem_ff[0][i] <= 32'(j_num_in[i][61:31]);
            q_quo_ff[0][i] <= '0;
         end
      end
   end

   for (genvar k = 0; k < DN; k++) begin : g_div
      logic [32:0] t_in  [3];
      logic        ge_in [3];

      // restoring divide digit, three lanes against the same norm
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t_in[i]  = {q_rem_ff[k][i], q_num_ff[k][i][DN-1-k]};
            ge_in[i] = t_in[i] >= 33'(q_den_ff[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) q_valid_ff[k+1] <= 1'b0;
         else if (advance) q_valid_ff[k+1] <= q_valid_ff[k];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            q_last_ff[k+1] <= q_last_ff[k];
            q_den_ff[k+1]  <= q_den_ff[k];
            q_num_ff[k+1]  <= q_num_ff[k];
            q_neg_ff[k+1]  <= q_neg_ff[k];
            for (int i = 0; i < 3; i++) begin
               q_rem_ff[k+1][i] <= ge_in[i] ? 32'(t_in[i] - 33'(q_den_ff[k]))
                                            : 32'(t_in[i]);
               q_quo_ff[k+1][i] <= q_quo_ff[k][i] | (31'(ge_in[i]) << (DN-1-k));
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stage k: signed unit vector in Q2.30
   acd_pkg::fix_type k_u_ff [3];
   logic             k_valid_ff, k_last_ff;

   always_ff @(posedge clock) begin
      if (reset) k_valid_ff <= 1'b0;
      else if (advance) k_valid_ff <= q_valid_ff[DN];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         k_last_ff <= q_last_ff[DN];
         for (int i = 0; i < 3; i++) begin
            k_u_ff[i] <= q_neg_ff[DN][i] ? -32'(q_quo_ff[DN][i]) : 32'(q_quo_ff[DN][i]);
         end
      end
   end

   // ---------------------------------------------------------------
   // stage l: complex current times each unit component
   logic signed [63:0] l_prod_ff [6];
   logic               l_valid_ff, l_last_ff;

   always_ff @(posedge clock) begin
      if (reset) l_valid_ff <= 1'b0;
      else if (advance) l_valid_ff <= k_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         l_last_ff <= k_last_ff;
         for (int i = 0; i < 3; i++) begin
            l_prod_ff[2*i]   <= 64'(current_real_ff) * 64'(k_u_ff[i]);
            l_prod_ff[2*i+1] <= 64'(current_imag_ff) * 64'(k_u_ff[i]);
         end
      end
   end

   // ---------------------------------------------------------------
   // stage m: round half up, drop 30 fraction bits, saturate; output register
   logic signed [63:0] m_round_in [6];
   acd_pkg::fix_type   m_sat_in   [6];
   acd_pkg::fix_type   rsp_j_ff   [6];
   logic               rsp_last_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         m_round_in[i] = (l_prod_ff[i] + 64'sd536870912) >>> 30;
         if (m_round_in[i] > 64'sd2147483647)       m_sat_in[i] = 32'sh7fffffff;
         else if (m_round_in[i] < -64'sd2147483648) m_sat_in[i] = 32'sh80000000;
         else                                       m_sat_in[i] = m_round_in[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= l_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_last_ff <= l_last_ff;
         rsp_j_ff    <= m_sat_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_j_x_real = rsp_j_ff[0];
   assign rsp_j_x_imag = rsp_j_ff[1];
   assign rsp_j_y_real = rsp_j_ff[2];
   assign rsp_j_y_imag = rsp_j_ff[3];
   assign rsp_j_z_real = rsp_j_ff[4];
   assign rsp_j_z_imag = rsp_j_ff[5];
   assign rsp_last_out = rsp_last_ff;

endmodule

### rtl/acd_checker.sv
`timescale 1ns / 1ps
// port level checks for the axisymmetric current direction unit
// depends on the top level ports only; bound to the top level below

module acd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_j_x_real,
   input logic signed [31:0] rsp_j_z_imag,
   input logic               rsp_last_out
);

   // reset empties the pipeline
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // requests are held back only behind a held result
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // a held result freezes the whole pipeline, request side included
   a_stall_spreads: assert property (@(posedge clock)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while result held");

   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_j_x_real) && $stable(rsp_j_z_imag)
          && $stable(rsp_last_out)))
      else $error("held result changed");

endmodule

bind axisymmetric_current_direction_unit acd_checker u_acd_checker (.*);

### tb/sv/tb_axisymmetric_current_direction_unit.sv
`timescale 1ns / 1ps
// self-checking bench for the axisymmetric current direction unit: a local
// fixed-point predictor feeds a queue that each accepted result is checked against
// depends on acd_pkg and the unit rtl

module tb_axisymmetric_current_direction_unit;

   typedef struct {
      logic signed [31:0] xr, xi, yr, yi, zr, zi;
      logic               last;
   } current_vec_type;

   // register copies held by the predictor
   logic signed [63:0] cur_re, cur_im;
   logic signed [63:0] org [3];
   logic signed [63:0] axv [3];

   // rounding toward minus infinity
   function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
      shr_floor = v >>> s;
   endfunction

   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      magnitude = (v < 0) ? -v : v;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      root_floor = res;
   endfunction

   function automatic logic signed [31:0] scale_sat(logic signed [63:0] c,
                                                    logic signed [63:0] u);
      logic signed [63:0] v;
      v = shr_floor(c * u + (64'sd1 << 29), 30);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      scale_sat = v[31:0];
   endfunction

   // direction of the current at one node, scaled by the complex current
   function automatic current_vec_type node_current(
         logic signed [acd_pkg::COORD_WIDTH-1:0] nx,
         logic signed [acd_pkg::COORD_WIDTH-1:0] ny,
         logic signed [acd_pkg::COORD_WIDTH-1:0] nz,
         logic vl);
      logic signed [63:0] p [3];
      logic signed [63:0] r [3];
      logic signed [63:0] u [3];
      logic [63:0] m, sum, n, q, a;
      int len;
      current_vec_type res;
      p[0] = shr_floor(64'(nx) - org[0], acd_pkg::PSHIFT);
      p[1] = shr_floor(64'(ny) - org[1], acd_pkg::PSHIFT);
      p[2] = shr_floor(64'(nz) - org[2], acd_pkg::PSHIFT);
      r[0] = axv[1] * p[2] - axv[2] * p[1];
      r[1] = axv[2] * p[0] - axv[0] * p[2];
      r[2] = axv[0] * p[1] - axv[1] * p[0];
      m = magnitude(r[0]);
      if (magnitude(r[1]) > m) m = magnitude(r[1]);
      if (magnitude(r[2]) > m) m = magnitude(r[2]);
      if (m == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0;
      end else begin
         len = 0;
         while (len < 64 && (m >> len) != 0) len++;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            if (len > 31) r[i] = shr_floor(r[i], len - 31);
            else r[i] = r[i] <<< (31 - len);
            a = magnitude(r[i]);
            sum = sum + a * a;
         end
         n = root_floor(sum);
         if (n == 0) n = 1;
         for (int i = 0; i < 3; i++) begin
            q = ((magnitude(r[i]) << 30) + (n >> 1)) / n;
            u[i] = (r[i] < 0) ? -$signed(q) : $signed(q);
         end
      end
      res.xr = scale_sat(cur_re, u[0]); res.xi = scale_sat(cur_im, u[0]);
      res.yr = scale_sat(cur_re, u[1]); res.yi = scale_sat(cur_im, u[1]);
      res.zr = scale_sat(cur_re, u[2]); res.zi = scale_sat(cur_im, u[2]);
      res.last = vl;
      node_current = res;
   endfunction

   // queue of expected node currents and the checks against it
   class current_scoreboard;
      current_vec_type pending [$];
      int errors;

      function void note_request(current_vec_type e);
         pending.push_back(e);
      endfunction

      function void check_field(string name, logic signed [31:0] e, logic signed [31:0] a);
         if (e !== a) begin
            $error("%s expected %0d actual %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(current_vec_type a);
         current_vec_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         check_field("j_x_real", e.xr, a.xr);
         check_field("j_x_imag", e.xi, a.xi);
         check_field("j_y_real", e.yr, a.yr);
         check_field("j_y_imag", e.yi, a.yi);
         check_field("j_z_real", e.zr, a.zr);
         check_field("j_z_imag", e.zi, a.zi);
         if (e.last !== a.last) begin
            $error("last_out expected %0d actual %0d", e.last, a.last);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, req_vertex_last;
   logic signed [acd_pkg::COORD_WIDTH-1:0] req_node_x, req_node_y, req_node_z;
   logic rsp_valid, rsp_stall, rsp_last_out;
   logic signed [31:0] rsp_j_x_real, rsp_j_x_imag, rsp_j_y_real;
   logic signed [31:0] rsp_j_y_imag, rsp_j_z_real, rsp_j_z_imag;
   logic csr_wen;
   logic [2:0] csr_index;
   logic [acd_pkg::CSR_WIDTH-1:0] csr_wdata;
   logic rsp_draining;

   current_scoreboard board;

   axisymmetric_current_direction_unit dut (.*);

   // clock
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // gap length, mostly short with the odd long one
   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) gap_len = 0;
      else if (k < 92) gap_len = $urandom_range(1, 3);
      else gap_len = $urandom_range(10, 40);
   endfunction

   // result side: random stall, checks on each accepted result
   initial begin
      current_vec_type got;
      int hold;
      rsp_stall = 1'b0;
      hold = 0;
      @(posedge clock iff !reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.xr = rsp_j_x_real; got.xi = rsp_j_x_imag;
            got.yr = rsp_j_y_real; got.yi = rsp_j_y_imag;
            got.zr = rsp_j_z_real; got.zi = rsp_j_z_imag;
            got.last = rsp_last_out;
            board.check_result(got);
         end
         if (hold > 0) hold--;
         else if (!rsp_draining && $urandom_range(0, 3) == 0) hold = gap_len();
         rsp_stall <= (hold > 0);
      end
   end

   // one register write, then the write port idles before the task returns
   task automatic write_reg(acd_pkg::csr_index_type idx, logic signed [31:0] v);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= acd_pkg::CSR_WIDTH'(v);
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         acd_pkg::CSR_CURRENT_REAL: cur_re = 64'(v);
         acd_pkg::CSR_CURRENT_IMAG: cur_im = 64'(v);
         acd_pkg::CSR_ORIGIN_X:     org[0] = 64'(v);
         acd_pkg::CSR_ORIGIN_Y:     org[1] = 64'(v);
         acd_pkg::CSR_ORIGIN_Z:     org[2] = 64'(v);
         acd_pkg::CSR_AXIS_X:       axv[0] = 64'(v);
         acd_pkg::CSR_AXIS_Y:       axv[1] = 64'(v);
         acd_pkg::CSR_AXIS_Z:       axv[2] = 64'(v);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one request through the valid/stall handshake
   task automatic send_node(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic vl, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_node_x <= x; req_node_y <= y; req_node_z <= z;
      req_vertex_last <= vl;
      @(posedge clock iff !req_stall);
      board.note_request(node_current(x, y, z, vl));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      rsp_draining = 1'b1;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      rsp_draining = 1'b0;
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: rand_word = 32'sh7fffffff;
         1: rand_word = 32'sh80000000;
         2: rand_word = 0;
         3: rand_word = $signed($urandom_range(0, 'h3ffff)) - 'sh20000;
         default: rand_word = $urandom;
      endcase
   endfunction

   task automatic random_config();
      write_reg(acd_pkg::CSR_CURRENT_REAL, rand_word());
      write_reg(acd_pkg::CSR_CURRENT_IMAG, rand_word());
      write_reg(acd_pkg::CSR_ORIGIN_X, rand_word());
      write_reg(acd_pkg::CSR_ORIGIN_Y, rand_word());
      write_reg(acd_pkg::CSR_ORIGIN_Z, rand_word());
      write_reg(acd_pkg::CSR_AXIS_X, rand_word());
      write_reg(acd_pkg::CSR_AXIS_Y, rand_word());
      write_reg(acd_pkg::CSR_AXIS_Z, rand_word());
   endtask

   initial begin
      board = new();
      rsp_draining = 1'b0;
      cur_re = 0; cur_im = 0;
      for (int i = 0; i < 3; i++) begin
         org[i] = 0; axv[i] = 0;
      end
      reset = 1'b1;
      req_valid = 1'b0; req_node_x = '0; req_node_y = '0; req_node_z = '0;
      req_vertex_last = 1'b0;
      csr_wen = 1'b0; csr_index = acd_pkg::CSR_CURRENT_REAL; csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero axis after reset gives zero current
      send_node(32'sh7fffffff, 32'sh80000000, 0, 1'b1, 0);
      wait_drained();
      // z axis, unit current, full-scale overflow with minus full current
      write_reg(acd_pkg::CSR_CURRENT_REAL, 32'sh80000000);
      write_reg(acd_pkg::CSR_CURRENT_IMAG, 32'sh00010000);
      write_reg(acd_pkg::CSR_AXIS_Z, 32'sh00010000);
      send_node(32'sh00010000, 0, 0, 1'b0, 0);
      send_node(0, 32'sh80000000, 0, 1'b1, 0);
      send_node(0, 0, 32'sh7fffffff, 1'b0, 0);   // on the axis
      send_node(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b1, 0);
      send_node(32'sh80000000, 32'sh7fffffff, 32'sh00001234, 1'b0, 0);
      send_node(32'sh00000001, 32'shffffffff, 0, 1'b1, 0);
      wait_drained();
      // extreme axis and origin
      write_reg(acd_pkg::CSR_AXIS_X, 32'sh80000000);
      write_reg(acd_pkg::CSR_AXIS_Y, 32'sh7fffffff);
      write_reg(acd_pkg::CSR_AXIS_Z, 32'sh80000000);
      write_reg(acd_pkg::CSR_ORIGIN_X, 32'sh7fffffff);
      write_reg(acd_pkg::CSR_ORIGIN_Y, 32'sh80000000);
      write_reg(acd_pkg::CSR_ORIGIN_Z, 32'sh7fffffff);
      write_reg(acd_pkg::CSR_CURRENT_REAL, 32'sh7fffffff);
      write_reg(acd_pkg::CSR_CURRENT_IMAG, 32'sh80000000);
      send_node(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0, 0);
      send_node(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1, 0);
      send_node(0, 0, 0, 1'b0, 0);
      wait_drained();
      // zero current
      write_reg(acd_pkg::CSR_CURRENT_REAL, 0);
      write_reg(acd_pkg::CSR_CURRENT_IMAG, 0);
      send_node(32'sh00050000, 32'shfff00000, 32'sh00030000, 1'b1, 0);
      wait_drained();

      // random phases, each under a fresh setting
      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         for (int k = 0; k < 50; k++) begin
            send_node(rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                      ph != 3);
            // hold off the sender until the pipeline drains
            if (ph == 5 && k == 25) wait_drained();
         end
         wait_drained();
      end

      repeat (acd_pkg::LATENCY + 20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_axisymmetric_current_direction_unit passed");
      else
         $display("tb_axisymmetric_current_direction_unit failed");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("tb_axisymmetric_current_direction_unit failed");
      $finish;
   end

endmodule

### files.f
rtl/acd_pkg.sv
rtl/axisymmetric_current_direction_unit.sv
rtl/acd_checker.sv
tb/sv/tb_axisymmetric_current_direction_unit.sv
